FILE: src/affine_transform_accumulator_assert.svh
// Assertion macros shared by the transform accumulator RTL.
`ifndef AFFINE_TRANSFORM_ACCUMULATOR_ASSERT_SVH
`define AFFINE_TRANSFORM_ACCUMULATOR_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define ATA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition that must never hold outside reset.
`define ATA_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

FILE: src/ata_pkg.sv
// Types, constants and the microcode program of the transform accumulator.
package ata_pkg;

  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned NUM_ELEMS = 16;
  localparam logic [3:0]  LAST_ELEM = 4'(NUM_ELEMS - 1);
  localparam logic [31:0] FX_ONE    = 32'd1 << FRAC_BITS;

  localparam logic CMD_TRANSLATE = 1'b0;
  localparam logic CMD_SCALE     = 1'b1;

  // Sequencer steps
  localparam logic [1:0] STEP_IDLE = 2'd0;
  localparam logic [1:0] STEP_READ = 2'd1;
  localparam logic [1:0] STEP_MUL  = 2'd2;
  localparam logic [1:0] STEP_WB   = 2'd3;

  typedef struct packed {
    logic        command;
    logic [31:0] vec_x;
    logic [31:0] vec_y;
    logic [31:0] vec_z;
  } in_req_t;

  typedef struct packed {
    logic [3:0]  element_index;
    logic [31:0] element_value;
    logic        last_element;
  } out_rsp_t;

  typedef enum logic [1:0] {
    WAIT_NONE,
    WAIT_IN,
    WAIT_OUT
  } wait_e;

  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_ADD,
    MODE_MUL
  } mac_mode_e;

  typedef struct packed {
    logic      en;
    mac_mode_e mode;
  } mac_ctrl_t;

  typedef struct packed {
    logic       accept;
    logic       rd;
    logic       mul;
    logic       wb;
    wait_e      wt;
    logic       br_last;
    logic [1:0] br_tgt;
    logic [1:0] seq;
  } ucode_t;

  // Control store: accept per request, then read, multiply, write back per element.
  function automatic ucode_t ata_ucode(input logic [1:0] step);
    ucode_t uc;
    uc = '0;
    unique case (step)
      STEP_IDLE: begin
        uc.accept = 1'b1;
        uc.wt     = WAIT_IN;
        uc.seq    = STEP_READ;
      end
      STEP_READ: begin
        uc.rd  = 1'b1;
        uc.wt  = WAIT_NONE;
        uc.seq = STEP_MUL;
      end
      STEP_MUL: begin
        uc.mul = 1'b1;
        uc.wt  = WAIT_NONE;
        uc.seq = STEP_WB;
      end
      STEP_WB: begin
        uc.wb      = 1'b1;
        uc.wt      = WAIT_OUT;
        uc.br_last = 1'b1;
        uc.br_tgt  = STEP_IDLE;
        uc.seq     = STEP_READ;
      end
    endcase
    return uc;
  endfunction

  function automatic logic [31:0] ata_ident(input logic [3:0] addr);
    return (addr[1:0] == addr[3:2]) ? FX_ONE : 32'd0;
  endfunction

endpackage

FILE: src/affine_transform_accumulator.sv
// Top level: microcoded sequencer, matrix store and output register.
//
// Keeps a 4x4 row-major transform matrix in signed Q16.16. Each request on
// the input channel (in_valid_i / in_stall_o / in_data_i) carries a command
// and a vector: translate post-multiplies the matrix by a translation,
// scale pre-multiplies rows 0..2 by x, y and z. Results saturate to 32 bits.
// After each request the block sends all sixteen elements in index order on
// the output channel (out_valid_o / out_stall_i / out_data_o), with
// last_element set on element 15.
// Sequencing: a request is taken in the idle step; each element then passes
// through the store read, multiply and write-back steps, and the next request
// is taken only after element 15 is written back. The single shared
// multiplier is used once per element. A stalled output holds its element;
// the write-back step waits until the output register frees. Reset restores
// the identity matrix at once.
module affine_transform_accumulator (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  ata_pkg::in_req_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output ata_pkg::out_rsp_t out_data_o
);
  import ata_pkg::*;

`include "affine_transform_accumulator_assert.svh"

  logic [1:0]  step_q, step_d;
  ucode_t      uc;
  logic        go;
  logic        out_free;
  logic        accept;
  logic        wb_fire;

  logic        cmd_q;
  logic [31:0] vx_q, vy_q, vz_q;
  logic [3:0]  elem_q;

  logic [31:0] mem_q [NUM_ELEMS];
  logic [15:0] mem_vld_q;
  logic [31:0] rd_elem_q, rd_w_q;
  logic [3:0]  w_addr;

  mac_ctrl_t          mac_ctrl;
  logic signed [31:0] op_a, op_b, res;
  logic [31:0]        vsel;

  logic        out_valid_q;
  out_rsp_t    out_data_q;

  // Sequencer
  assign uc       = ata_ucode(step_q);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    unique case (uc.wt)
      WAIT_IN:  go = in_valid_i;
      WAIT_OUT: go = out_free;
      default:  go = 1'b1;
    endcase
    if (!go) begin
      step_d = step_q;
    end else if (uc.br_last && elem_q == LAST_ELEM) begin
      step_d = uc.br_tgt;
    end else begin
      step_d = uc.seq;
    end
  end

  assign accept     = uc.accept && in_valid_i;
  assign wb_fire    = uc.wb && go;
  assign in_stall_o = !uc.accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_IDLE;
      elem_q <= '0;
    end else begin
      step_q <= step_d;
      if (accept) begin
        elem_q <= '0;
      end else if (wb_fire) begin
        elem_q <= elem_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= in_data_i.command;
      vx_q  <= in_data_i.vec_x;
      vy_q  <= in_data_i.vec_y;
      vz_q  <= in_data_i.vec_z;
    end
  end

  // Matrix store; entries not yet written read as identity
  assign w_addr = {elem_q[3:2], 2'b11};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_vld_q <= '0;
    end else if (wb_fire) begin
      mem_vld_q[elem_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wb_fire) begin
      mem_q[elem_q] <= res;
    end
    if (uc.rd) begin
      rd_elem_q <= mem_vld_q[elem_q] ? mem_q[elem_q] : ata_ident(elem_q);
      rd_w_q    <= mem_vld_q[w_addr] ? mem_q[w_addr] : ata_ident(w_addr);
    end
  end

  // Operand selection
  always_comb begin
    unique case (cmd_q == CMD_SCALE ? elem_q[3:2] : elem_q[1:0])
      2'd0:    vsel = vx_q;
      2'd1:    vsel = vy_q;
      2'd2:    vsel = vz_q;
      default: vsel = '0;
    endcase
    mac_ctrl.en = uc.mul;
    if (cmd_q == CMD_SCALE) begin
      op_a          = vsel;
      op_b          = rd_elem_q;
      mac_ctrl.mode = (elem_q[3:2] == 2'd3) ? MODE_PASS : MODE_MUL;
    end else begin
      op_a          = rd_w_q;
      op_b          = vsel;
      mac_ctrl.mode = (elem_q[1:0] == 2'd3) ? MODE_PASS : MODE_ADD;
    end
  end

  ata_mac u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (mac_ctrl),
    .op_a_i   (op_a),
    .op_b_i   (op_b),
    .addend_i (rd_elem_q),
    .res_o    (res)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (wb_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wb_fire) begin
      out_data_q.element_index <= elem_q;
      out_data_q.element_value <= res;
      out_data_q.last_element  <= (elem_q == LAST_ELEM);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  `ATA_ASSERT(a_last_is_fifteen,
    out_valid_o && out_data_o.last_element |-> out_data_o.element_index == LAST_ELEM,
    "last_element on an index other than fifteen")
  `ATA_ASSERT(a_last_returns_idle,
    wb_fire && elem_q == LAST_ELEM |=> step_q == STEP_IDLE,
    "sequencer did not return to idle after the last element")
  `ATA_ASSERT(a_accept_clears_index,
    accept |=> elem_q == 4'd0 && step_q == STEP_READ,
    "request accept did not restart the element walk")
  `ATA_ASSERT_NEVER(a_no_overwrite,
    wb_fire && out_valid_q && out_stall_i,
    "write back overwrote a stalled output element")

endmodule

FILE: src/ata_mac.sv
// Registered 32x32 multiply, fixed-point shift, optional add and saturation.
module ata_mac (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ata_pkg::mac_ctrl_t  ctrl_i,
  input  logic signed [31:0]  op_a_i,
  input  logic signed [31:0]  op_b_i,
  input  logic signed [31:0]  addend_i,
  output logic signed [31:0]  res_o
);
  import ata_pkg::*;

  logic signed [63:0] prod_q;
  logic signed [31:0] add_q;
  mac_mode_e          mode_q;
  logic signed [63:0] shifted;
  logic signed [64:0] sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_PASS;
    end else if (ctrl_i.en) begin
      mode_q <= ctrl_i.mode;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      prod_q <= op_a_i * op_b_i;
      add_q  <= addend_i;
    end
  end

  always_comb begin
    shifted = prod_q >>> FRAC_BITS;
    unique case (mode_q)
      MODE_ADD: sum = {{33{add_q[31]}}, add_q} + {shifted[63], shifted};
      MODE_MUL: sum = {shifted[63], shifted};
      default:  sum = {{33{add_q[31]}}, add_q};
    endcase
    // fits when bits 64..31 all agree
    if (&sum[64:31] || ~|sum[64:31]) begin
      res_o = sum[31:0];
    end else if (sum[64]) begin
      res_o = 32'sh8000_0000;
    end else begin
      res_o = 32'sh7fff_ffff;
    end
  end

endmodule
